### sv/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg
// shared types, constants and twiddle table for the radix-2 fft block
// ----------------------------------------------------------------------------
package rcf_pkg;

  localparam int MAX_POINTS   = 64;
  localparam int SAMPLE_BITS  = 16;
  localparam int TWIDDLE_BITS = 16;
  localparam int FRAC         = TWIDDLE_BITS - 1;
  localparam int DATA_BITS    = 23;
  localparam int STORE        = 64;
  localparam int ADDR_BITS    = 6;
  localparam int CNT_BITS     = 7;
  localparam int CAP          = (MAX_POINTS > STORE) ? STORE : MAX_POINTS;
  localparam int PROD_BITS    = DATA_BITS + TWIDDLE_BITS;
  localparam int SUM_BITS     = PROD_BITS + 1;

  typedef logic signed [DATA_BITS-1:0]    data_t;
  typedef logic signed [TWIDDLE_BITS-1:0] twid_t;
  typedef logic [ADDR_BITS-1:0]           addr_t;

  // butterfly unit request
  typedef struct packed {
    logic  go;
    data_t ar;
    data_t ai;
    data_t er;
    data_t ei;
    twid_t c;
    twid_t d;
  } bfly_req_t;

  // butterfly unit result
  typedef struct packed {
    logic  done;
    data_t xr;
    data_t xi;
    data_t yr;
    data_t yi;
  } bfly_rsp_t;

  function automatic logic [24:0] qsine(input logic [4:0] k);
    logic [24:0] v;
    case (k)
      5'd0:  v = 25'd0;
      5'd1:  v = 25'd1644455;
      5'd2:  v = 25'd3273072;
      5'd3:  v = 25'd4870169;
      5'd4:  v = 25'd6420363;
      5'd5:  v = 25'd7908725;
      5'd6:  v = 25'd9320922;
      5'd7:  v = 25'd10643353;
      5'd8:  v = 25'd11863283;
      5'd9:  v = 25'd12968963;
      5'd10: v = 25'd13949745;
      5'd11: v = 25'd14796184;
      5'd12: v = 25'd15500126;
      5'd13: v = 25'd16054795;
      5'd14: v = 25'd16454846;
      5'd15: v = 25'd16696429;
      5'd16: v = 25'd16777216;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

  function automatic twid_t to_twid(input logic [24:0] q24);
    logic [25:0] v;
    logic [25:0] top;
    v   = ({1'b0, q24} + (26'd1 << (24 - FRAC - 1))) >> (24 - FRAC);
    top = (26'd1 << FRAC) - 26'd1;
    if (v > top) v = top;
    return twid_t'(v[TWIDDLE_BITS-1:0]);
  endfunction

  function automatic twid_t sin64(input logic [5:0] k);
    logic [4:0] q;
    twid_t      m;
    q = (k[4:0] <= 5'd16) ? k[4:0] : 5'(6'd32 - {1'b0, k[4:0]});
    m = to_twid(qsine(q));
    return k[5] ? -m : m;
  endfunction

  function automatic twid_t cos64(input logic [5:0] k);
    return sin64(k + 6'd16);
  endfunction

  function automatic data_t sat(input logic signed [SUM_BITS-1:0] v);
    if (v > SUM_BITS'(4194303)) return data_t'(23'sd4194303);
    if (v < -SUM_BITS'(4194304)) return data_t'(-23'sd4194304);
    return data_t'(v[DATA_BITS-1:0]);
  endfunction

endpackage

### sv/rcf_bfly.sv
// ----------------------------------------------------------------------------
// rcf_bfly
// shared butterfly: one real multiply per cycle, then rounded sums
// ----------------------------------------------------------------------------
module rcf_bfly (
  input  logic              clk,
  input  logic              rst_n,
  input  rcf_pkg::bfly_req_t req,
  output rcf_pkg::bfly_rsp_t rsp
);
  import rcf_pkg::*;

  logic [2:0] step_r, step_nxt;
  bfly_req_t  q_r;
  logic signed [PROD_BITS-1:0] prod_r;
  logic signed [SUM_BITS-1:0]  accr_r, acci_r;
  logic signed [SUM_BITS-1:0]  rnd;
  logic signed [SUM_BITS-1:0]  tr_full, ti_full;
  // rotated term can reach about 1.41 * 2^22, so it keeps headroom above 23 bits
  logic signed [SUM_BITS-FRAC-1:0] tr_r, ti;
  data_t ma;
  twid_t mb;

  always_comb begin
    case (step_r)
      3'd1: begin ma = q_r.ar; mb = q_r.c; end
      3'd2: begin ma = q_r.ai; mb = q_r.d; end
      3'd3: begin ma = q_r.ai; mb = q_r.c; end
      default: begin ma = q_r.ar; mb = q_r.d; end
    endcase
  end

  assign rnd = SUM_BITS'(1) <<< (FRAC - 1);
  assign tr_full = accr_r + rnd;
  assign ti_full = acci_r + rnd;
  assign ti = ti_full[SUM_BITS-1:FRAC];
  assign step_nxt = (step_r == 3'd0) ? (req.go ? 3'd1 : 3'd0) :
                    (step_r == 3'd6) ? 3'd0 : step_r + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
    end else begin
      step_r <= step_nxt;
    end
    if (step_r == 3'd0 && req.go) q_r <= req;
    prod_r <= ma * mb;
    case (step_r)
      3'd2: accr_r <= SUM_BITS'(prod_r);
      3'd3: accr_r <= accr_r - SUM_BITS'(prod_r);
      3'd4: acci_r <= SUM_BITS'(prod_r);
      3'd5: begin
        acci_r <= acci_r + SUM_BITS'(prod_r);
        tr_r   <= tr_full[SUM_BITS-1:FRAC];
      end
      default: ;
    endcase
  end

  // products finish at steps 2..5, as prod_r is registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= (step_r == 3'd6);
    end
    if (step_r == 3'd6) begin
      rsp.xr <= sat(SUM_BITS'(q_r.er) + SUM_BITS'(tr_r));
      rsp.yr <= sat(SUM_BITS'(q_r.er) - SUM_BITS'(tr_r));
      rsp.xi <= sat(SUM_BITS'(q_r.ei) + SUM_BITS'(ti));
      rsp.yi <= sat(SUM_BITS'(q_r.ei) - SUM_BITS'(ti));
    end
  end
endmodule

### sv/radix2_complex_fft.sv
// ----------------------------------------------------------------------------
// radix2_complex_fft
// radix-2 decimation-in-time fft over up to 64 complex samples
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while busy is low; the one with
// in_last_sample starts the transform. The frame is zero-padded to the next
// power of two n. Bit-reverse reordering swaps each pair in place, then each
// butterfly does the two memory reads, the four products and the rounding
// in the shared multiplier, and the two writes. A priming read then leads
// the output, and n bins stream out one per cycle in natural order.
// busy stays high from the last sample until the last bin. The receiver
// cannot stall: every out_valid pulse is a transfer.
module radix2_complex_fft (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  input  logic start,
  output logic busy,
  input  logic signed [rcf_pkg::SAMPLE_BITS-1:0] in_sample_re,
  input  logic signed [rcf_pkg::SAMPLE_BITS-1:0] in_sample_im,
  input  logic in_last_sample,
  output logic out_valid,
  output logic signed [22:0] out_bin_re,
  output logic signed [22:0] out_bin_im,
  output logic [5:0] out_bin_index,
  output logic out_last_bin,
  output logic out_dropped
);
  import rcf_pkg::*;

  typedef enum logic [6:0] {
    S_LOAD = 7'b0000001,
    S_PAD  = 7'b0000010,
    S_REV  = 7'b0000100,
    S_RD   = 7'b0001000,
    S_BF   = 7'b0010000,
    S_WR   = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   dir_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic   ovf_r;
  logic [CNT_BITS-1:0] n_r;
  logic [2:0] lg_r;
  logic [CNT_BITS-1:0] idx_r;   // general index (pad, reverse, output)
  logic [2:0] ph_r;             // sub-step within a state
  logic [2:0] stage_r;          // log2 of half
  logic [ADDR_BITS-1:0] j_r, i_r;
  data_t  tmp_re_r, tmp_im_r;
  data_t  e_re_r, e_im_r, a_re_r, a_im_r;

  // sample and butterfly store, one read and one write port
  data_t mem_re [STORE];
  data_t mem_im [STORE];
  logic  we;
  addr_t wa, ra;
  data_t wd_re, wd_im, rd_re_r, rd_im_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_re[wa] <= wd_re;
      mem_im[wa] <= wd_im;
    end
    rd_re_r <= mem_re[ra];
    rd_im_r <= mem_im[ra];
  end

  bfly_req_t breq;
  bfly_rsp_t brsp;
  rcf_bfly u_bfly (.clk(clk), .rst_n(rst_n), .req(breq), .rsp(brsp));

  // bit reverse of idx over lg bits
  addr_t rev;
  always_comb begin
    rev = '0;
    for (int b = 0; b < ADDR_BITS; b++)
      if (b < int'(lg_r)) rev[int'(lg_r) - 1 - b] = idx_r[b];
  end

  logic [ADDR_BITS-1:0] half, o_addr, kk;
  assign half   = ADDR_BITS'(1) << stage_r;
  assign o_addr = i_r + half;
  assign kk     = ADDR_BITS'(j_r << (ADDR_BITS - 1 - stage_r));

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_r != S_LOAD);

  logic [CNT_BITS-1:0] cnt_new;
  logic [CNT_BITS-1:0] n_calc;
  logic [2:0] lg_calc;
  always_comb begin
    cnt_new = (cnt_r < CNT_BITS'(CAP)) ? cnt_r + 1'b1 : cnt_r;
    n_calc  = CNT_BITS'(1);
    lg_calc = 3'd0;
    for (int b = 0; b < ADDR_BITS; b++)
      if (n_calc < cnt_new) begin
        n_calc  = n_calc << 1;
        lg_calc = lg_calc + 3'd1;
      end
  end

  logic [CNT_BITS-1:0] i_next;
  assign i_next = CNT_BITS'(i_r) + (CNT_BITS'(half) << 1);

  // final butterfly of the final stage
  logic bf_last;
  assign bf_last = !(i_next < n_r) && !(CNT_BITS'(j_r) + 1'b1 < CNT_BITS'(half)) &&
                   !(stage_r + 3'd1 < lg_r);

  always_comb begin
    we = 1'b0; wa = '0; wd_re = '0; wd_im = '0;
    ra = idx_r[ADDR_BITS-1:0];
    breq = '0;
    breq.ar = a_re_r; breq.ai = a_im_r; breq.er = e_re_r; breq.ei = e_im_r;
    breq.c = cos64(kk);
    breq.d = dir_r ? sin64(kk) : -sin64(kk);
    state_nxt = state_r;
    case (state_r)
      S_LOAD: begin
        if (accept && cnt_r < CNT_BITS'(CAP)) begin
          we = 1'b1; wa = cnt_r[ADDR_BITS-1:0];
          wd_re = data_t'(in_sample_re); wd_im = data_t'(in_sample_im);
        end
        if (accept && in_last_sample) state_nxt = S_PAD;
      end
      S_PAD: begin
        if (idx_r < n_r) begin
          we = 1'b1; wa = idx_r[ADDR_BITS-1:0];
        end else begin
          state_nxt = S_REV;
        end
      end
      S_REV: begin
        // ph 0: read idx, ph 1: read rev, ph 2: write idx, ph 3: write rev
        ra = (ph_r == 3'd0) ? idx_r[ADDR_BITS-1:0] : rev;
        if (ph_r == 3'd2) begin
          we = 1'b1; wa = idx_r[ADDR_BITS-1:0]; wd_re = rd_re_r; wd_im = rd_im_r;
        end else if (ph_r == 3'd3) begin
          we = 1'b1; wa = rev; wd_re = tmp_re_r; wd_im = tmp_im_r;
        end
        if (idx_r == n_r) state_nxt = (n_r == CNT_BITS'(1)) ? S_OUT : S_RD;
      end
      S_RD: begin
        ra = (ph_r == 3'd0) ? i_r : o_addr;
        if (ph_r == 3'd2) begin
          breq.go = 1'b1;
          breq.ar = rd_re_r; breq.ai = rd_im_r;
          state_nxt = S_BF;
        end
      end
      S_BF: begin
        if (brsp.done) state_nxt = S_WR;
      end
      S_WR: begin
        we = 1'b1;
        if (ph_r == 3'd0) begin
          wa = i_r; wd_re = brsp.xr; wd_im = brsp.xi;
        end else begin
          wa = o_addr; wd_re = tmp_re_r; wd_im = tmp_im_r;
          state_nxt = bf_last ? S_OUT : S_RD;
        end
      end
      S_OUT: begin
        ra = idx_r[ADDR_BITS-1:0];
        if (ph_r != 3'd0 && idx_r == n_r) state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      dir_r <= 1'b0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      idx_r <= '0;
      ph_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) dir_r <= cfg_wdata;
      out_valid <= 1'b0;
      state_r <= state_nxt;
      case (state_r)
        S_LOAD: begin
          if (accept) begin
            cnt_r <= cnt_new;
            if (cnt_r >= CNT_BITS'(CAP)) ovf_r <= 1'b1;
            if (in_last_sample) begin
              n_r <= n_calc; lg_r <= lg_calc;
              idx_r <= cnt_new;
            end
          end
        end
        S_PAD: begin
          if (idx_r < n_r) idx_r <= idx_r + 1'b1;
          else begin idx_r <= '0; ph_r <= '0; end
        end
        S_REV: begin
          if (idx_r != n_r) begin
            if (CNT_BITS'(rev) <= idx_r) begin
              idx_r <= idx_r + 1'b1;
            end else begin
              if (ph_r == 3'd1) begin tmp_re_r <= rd_re_r; tmp_im_r <= rd_im_r; end
              ph_r <= (ph_r == 3'd3) ? 3'd0 : ph_r + 3'd1;
              if (ph_r == 3'd3) idx_r <= idx_r + 1'b1;
            end
          end else begin
            idx_r <= '0; ph_r <= '0;
            stage_r <= '0; j_r <= '0; i_r <= '0;
          end
        end
        S_RD: begin
          if (ph_r == 3'd1) begin e_re_r <= rd_re_r; e_im_r <= rd_im_r; end
          if (ph_r == 3'd2) begin a_re_r <= rd_re_r; a_im_r <= rd_im_r; end
          ph_r <= (ph_r == 3'd2) ? 3'd0 : ph_r + 3'd1;
        end
        S_BF: begin
          if (brsp.done) begin
            tmp_re_r <= brsp.yr; tmp_im_r <= brsp.yi;
            e_re_r <= brsp.xr; e_im_r <= brsp.xi;
            ph_r <= '0;
          end
        end
        S_WR: begin
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1;
          end else begin
            ph_r <= '0;
            // walk i over the groups, then j, then the stage
            if (i_next < n_r) begin
              i_r <= i_next[ADDR_BITS-1:0];
            end else if (CNT_BITS'(j_r) + 1'b1 < CNT_BITS'(half)) begin
              j_r <= j_r + 1'b1; i_r <= j_r + 1'b1;
            end else if (stage_r + 3'd1 < lg_r) begin
              stage_r <= stage_r + 3'd1; j_r <= '0; i_r <= '0;
            end else begin
              idx_r <= '0;
            end
          end
        end
        S_OUT: begin
          // ph 0 primes the read, then one bin per cycle
          if (ph_r == 3'd0) begin
            ph_r <= 3'd1; idx_r <= idx_r + 1'b1;
          end else begin
            out_valid     <= 1'b1;
            out_bin_re    <= rd_re_r;
            out_bin_im    <= rd_im_r;
            out_bin_index <= 6'(idx_r - 1'b1);
            out_last_bin  <= (idx_r == n_r);
            out_dropped   <= ovf_r;
            if (idx_r == n_r) begin
              cnt_r <= '0; ovf_r <= 1'b0;
              idx_r <= '0; ph_r <= '0;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // bins only come while transforming output
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_OUT)) else $error("bin outside output phase");
  // fill count never exceeds capacity
  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_BITS'(CAP)) else $error("fill count beyond capacity");
  // the last bin returns the block to loading
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_bin |-> !busy) else $error("busy after last bin");
`endif
endmodule

### tb/radix2_complex_fft_tb.sv
// ----------------------------------------------------------------------------
// radix2_complex_fft_tb
// self-checking bench: directed table, an overrun frame, then random frames,
// bins checked against an in-bench fixed-point fft predictor
// ----------------------------------------------------------------------------
module radix2_complex_fft_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rcf_pkg::*;

  // one expected bin
  typedef struct {
    logic signed [22:0] re;
    logic signed [22:0] im;
    logic [5:0]         idx;
    logic               lastb;
    logic               drop;
  } bin_t;

  // directed stimulus row; has_exp marks rows with a typed-in first bin
  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               lastf;
    bit                 has_exp;
    logic signed [22:0] exp_re;
    logic signed [22:0] exp_im;
  } row_t;

  localparam int LIMIT = 3_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_sample_re = '0;
  logic signed [15:0] in_sample_im = '0;
  logic in_last_sample = 1'b0;
  logic out_valid;
  logic signed [22:0] out_bin_re;
  logic signed [22:0] out_bin_im;
  logic [5:0] out_bin_index;
  logic out_last_bin;
  logic out_dropped;

  radix2_complex_fft dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy),
    .in_sample_re(in_sample_re), .in_sample_im(in_sample_im),
    .in_last_sample(in_last_sample),
    .out_valid(out_valid), .out_bin_re(out_bin_re), .out_bin_im(out_bin_im),
    .out_bin_index(out_bin_index), .out_last_bin(out_last_bin),
    .out_dropped(out_dropped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: frame buffer, count, overflow flag, direction copy
  longint frame_re[64];
  longint frame_im[64];
  int     held;
  bit     spilled;
  bit     inverse;

  bin_t bins_due[$];
  bin_t head_bin;  // bin 0 of the latest frame
  int   mismatches;
  bit   failed;
  longint cycles;

  // ---------------------------------------------------------------- predictor
  function automatic longint clip23(longint v);
    if (v > 4194303) return 4194303;
    if (v < -4194304) return -4194304;
    return v;
  endfunction

  // quarter-wave sine in q0.24, rounded to q1.15 and held below +1.0
  function automatic longint sine_q15(int k);
    longint qtab[17] = '{0, 1644455, 3273072, 4870169, 6420363, 7908725,
      9320922, 10643353, 11863283, 12968963, 13949745, 14796184, 15500126,
      16054795, 16454846, 16696429, 16777216};
    longint v;
    int q;
    k = k & 63;
    if (k >= 32) return -sine_q15(k - 32);
    q = (k <= 16) ? k : 32 - k;
    v = (qtab[q] + (64'sd1 << (24 - FRAC - 1))) >>> (24 - FRAC);
    if (v > (64'sd1 << FRAC) - 1) v = (64'sd1 << FRAC) - 1;
    return v;
  endfunction

  // round half toward +inf after dropping the twiddle fraction
  function automatic longint round_frac(longint x);
    return (x + (64'sd1 << (FRAC - 1))) >>> FRAC;
  endfunction

  // take one sample; on the frame's last one run the fft and queue its bins
  task automatic fft_accept(input logic signed [15:0] re,
                            input logic signed [15:0] im, input logic lastf);
    int n, lg, r, t, half, span, k;
    longint c, d, a, b, tr, ti, er, ei, x;
    bin_t bn;
    if (held < CAP) begin
      frame_re[held] = re;
      frame_im[held] = im;
      held++;
    end else begin
      spilled = 1'b1;
    end
    if (!lastf) return;
    n = 1;
    lg = 0;
    while (n < held && n < 64) begin
      n = n << 1;
      lg++;
    end
    for (int i = held; i < n; i++) begin
      frame_re[i] = 0;
      frame_im[i] = 0;
    end
    // bit-reverse reorder
    for (int i = 0; i < n; i++) begin
      r = 0;
      t = i;
      for (int q = 0; q < lg; q++) begin
        r = (r << 1) | (t & 1);
        t = t >> 1;
      end
      if (r > i) begin
        x = frame_re[i]; frame_re[i] = frame_re[r]; frame_re[r] = x;
        x = frame_im[i]; frame_im[i] = frame_im[r]; frame_im[r] = x;
      end
    end
    for (half = 1; half < n; half = half << 1) begin
      span = half << 1;
      for (int j = 0; j < half; j++) begin
        k = j * (64 / span);
        c = sine_q15(k + 16);
        d = inverse ? sine_q15(k) : -sine_q15(k);
        for (int i = j; i < n; i += span) begin
          a = frame_re[i + half];
          b = frame_im[i + half];
          tr = round_frac(a * c - b * d);
          ti = round_frac(b * c + a * d);
          er = frame_re[i];
          ei = frame_im[i];
          frame_re[i] = clip23(er + tr);
          frame_im[i] = clip23(ei + ti);
          frame_re[i + half] = clip23(er - tr);
          frame_im[i + half] = clip23(ei - ti);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      bn.re = frame_re[i][22:0];
      bn.im = frame_im[i][22:0];
      bn.idx = i[5:0];
      bn.lastb = (i == n - 1);
      bn.drop = spilled;
      if (i == 0) head_bin = bn;
      bins_due.push_back(bn);
    end
    held = 0;
    spilled = 1'b0;
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    bin_t e;
    if (rst_n && out_valid) begin
      if (bins_due.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected bin idx=%0d re=%0d im=%0d", out_bin_index,
                   out_bin_re, out_bin_im);
      end else begin
        e = bins_due.pop_front();
        if (out_bin_re !== e.re || out_bin_im !== e.im || out_bin_index !== e.idx ||
            out_last_bin !== e.lastb || out_dropped !== e.drop) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10) begin
            $display("bin mismatch exp re=%0d im=%0d idx=%0d last=%0b drop=%0b",
                     e.re, e.im, e.idx, e.lastb, e.drop);
            $display("             got re=%0d im=%0d idx=%0d last=%0b drop=%0b",
                     out_bin_re, out_bin_im, out_bin_index, out_last_bin,
                     out_dropped);
          end
        end
      end
    end
  end

  // watchdog on total cycles
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driving
  bit calm;  // no idle bursts in the closing stretch

  // one sample transfer: hold start until accepted with busy low
  task automatic send_sample(input logic signed [15:0] re,
                             input logic signed [15:0] im, input logic lastf);
    if (!calm && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start <= 1'b1;
    in_sample_re <= re;
    in_sample_im <= im;
    in_last_sample <= lastf;
    @(posedge clk);
    while (busy) @(posedge clk);
    fft_accept(re, im, lastf);
  endtask

  // wait until all bins are in, then some settle time before a write
  task automatic drain();
    start <= 1'b0;
    while (bins_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_direction(input bit inv);
    cfg_we <= 1'b1;
    cfg_wdata <= inv;
    @(posedge clk);
    cfg_we <= 1'b0;
    inverse = inv;
  endtask

  // frame with random content; length mostly small, sometimes near full or over
  task automatic random_frame(inout int sent);
    int len, pick;
    logic signed [15:0] re, im;
    pick = $urandom_range(0, 9);
    if (pick < 6) len = $urandom_range(1, 9);
    else if (pick < 8) len = $urandom_range(10, 20);
    else len = $urandom_range(60, 70);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 4))
        0: re = 16'sh7fff;
        1: re = 16'sh8000;
        default: re = 16'($urandom());
      endcase
      im = ($urandom_range(0, 4) == 0) ? 16'sh8000 : 16'($urandom());
      send_sample(re, im, i == len - 1);
      sent++;
    end
  endtask

  row_t plan[$];
  bin_t first_bin;
  int   sent;

  initial begin
    held = 0;
    spilled = 1'b0;
    inverse = 1'b0;
    mismatches = 0;
    failed = 1'b0;
    cycles = 0;
    calm = 1'b0;
    sent = 0;

    // single-sample frames echo the sample; a full-scale dc pair sums,
    // with the unit twiddle held one step below +1.0
    plan.push_back('{16'sh7fff, 16'sh8000, 1'b1, 1'b1, 23'sd32767, -23'sd32768});
    plan.push_back('{16'sh8000, 16'sh7fff, 1'b1, 1'b1, -23'sd32768, 23'sd32767});
    plan.push_back('{16'sh0000, 16'sh0000, 1'b1, 1'b1, 23'sd0, 23'sd0});
    plan.push_back('{16'sh7fff, 16'sh7fff, 1'b0, 1'b0, 0, 0});
    plan.push_back('{16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 23'sd65533, 23'sd65533});
    // three samples, padded to four
    plan.push_back('{16'sh5555, -16'sh2aaa, 1'b0, 1'b0, 0, 0});
    plan.push_back('{-16'sh1234, 16'sh0fed, 1'b0, 1'b0, 0, 0});
    plan.push_back('{16'sh0001, -16'sh0001, 1'b1, 1'b0, 0, 0});
    // five samples, padded to eight
    for (int i = 0; i < 5; i++)
      plan.push_back('{16'(i * 9000 - 20000), 16'(7000 - i * 5000), i == 4, 1'b0, 0, 0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int pass = 0; pass < 2; pass++) begin
      set_direction(pass[0]);
      foreach (plan[i]) begin
        send_sample(plan[i].re, plan[i].im, plan[i].lastf);
        sent++;
        if (plan[i].has_exp) begin
          first_bin = head_bin;
          if (first_bin.re !== plan[i].exp_re || first_bin.im !== plan[i].exp_im) begin
            failed = 1'b1;
            $display("table row %0d: predictor gives re=%0d im=%0d, table %0d %0d",
                     i, first_bin.re, first_bin.im, plan[i].exp_re, plan[i].exp_im);
          end
        end
      end
      drain();
    end

    // overrun frame of extremes: fills capacity, then ends past it
    for (int i = 0; i < 66; i++) begin
      send_sample((i & 1) ? 16'sh8000 : 16'sh7fff, (i & 2) ? 16'sh7fff : 16'sh8000,
                  i == 65);
      sent++;
    end
    drain();

    // random frames, direction flipped between phases
    while (sent < 100) begin
      set_direction(1'($urandom_range(0, 1)));
      random_frame(sent);
      drain();
    end
    set_direction(1'b1);
    random_frame(sent);
    drain();
    set_direction(1'b0);
    calm = 1'b1;
    for (int f = 0; f < 2; f++) random_frame(sent);
    start <= 1'b0;

    while (bins_due.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (!failed && bins_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
